/* sv/ocvm_pkg.sv */
`default_nettype none
package ocvm_pkg;

  localparam int MAX_VMS = 64;
  localparam int VM_W = $clog2(MAX_VMS);
  localparam int CNT_W = $clog2(MAX_VMS + 1);

  localparam int REQ_IDX_W = 6;
  localparam int AMT_W = 16;
  localparam int OUT_VM_W = 6;
  localparam int LIM_W = 4;
  localparam int JOB_W = 16;
  localparam int USE_W = 20;
  localparam int COST_W = 24;
  localparam int VMC_W = 7;
  localparam int LOG_W = 15;
  localparam int FRAC_W = 16;
  localparam int ROOT_W = 31;
  localparam int NUM_ROOTS = 16;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_VM_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_VM_COUNT = 1'b1;

  localparam logic REQ_ASSIGN = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic [VMC_W-1:0] VM_COUNT_RESET = 7'd64;
  localparam logic [LOG_W-1:0] LOG2_RESET = 15'd24576;
  localparam logic [LIM_W-1:0] LIM_TOP = 4'd15;
  localparam logic [JOB_W-1:0] JOB_MAX = 16'hFFFF;
  localparam logic [USE_W-1:0] USE_MAX = 20'hFFFFF;
  localparam logic [COST_W-1:0] COST_MAX = 24'hFFFFFF;

  localparam int POW_LAT = NUM_ROOTS + 2;
  localparam int PIPE_LAT = POW_LAT + 2;
  localparam int DRAIN_LEN = PIPE_LAT + 2;
  localparam int STEP_W = $clog2(MAX_VMS + DRAIN_LEN + 1);
  localparam int NUM_LANES = 6;

  typedef struct packed {
    logic [JOB_W-1:0] job;
    logic [USE_W-1:0] mem;
    logic [USE_W-1:0] net;
  } vm_state_t;

  typedef struct packed {
    logic shift;
    logic rel;
    logic asg;
    logic [AMT_W-1:0] mem_amt;
    logic [AMT_W-1:0] net_amt;
  } cell_cmd_t;

  typedef struct packed {
    logic valid;
    logic active;
    logic [VM_W-1:0] id;
  } scan_tag_t;

  typedef logic [ROOT_W-1:0] root_tab_t [NUM_ROOTS];

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = '0;
    b = 64'h1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (v >= r + b) begin
        v = v - r - b;
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic root_tab_t make_roots();
    root_tab_t t;
    logic [63:0] prev;
    prev = isqrt64(64'h1 << 61);
    t[0] = ROOT_W'(prev);
    for (int k = 1; k < NUM_ROOTS; k++) begin
      prev = isqrt64(prev << 30);
      t[k] = ROOT_W'(prev);
    end
    return t;
  endfunction

  localparam root_tab_t ROOTS = make_roots();

  function automatic logic [USE_W-1:0] sat_use(input logic [USE_W:0] v);
    return v[USE_W] ? USE_MAX : v[USE_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* sv/ocvm_if.sv */
`default_nettype none
interface ocvm_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic [ocvm_pkg::REQ_IDX_W-1:0] vm_index;
  logic [ocvm_pkg::AMT_W-1:0] mem_amount;
  logic [ocvm_pkg::AMT_W-1:0] net_amount;
  modport source (output valid, req_type, vm_index, mem_amount, net_amount, input ready);
  modport sink (input valid, req_type, vm_index, mem_amount, net_amount, output ready);
endinterface

interface ocvm_res_if;
  logic valid;
  logic ready;
  logic [ocvm_pkg::OUT_VM_W-1:0] target_vm;
  logic [ocvm_pkg::LIM_W-1:0] job_limit_log2;
  logic [ocvm_pkg::COST_W-1:0] least_cost;
  modport source (output valid, target_vm, job_limit_log2, least_cost, input ready);
  modport sink (input valid, target_vm, job_limit_log2, least_cost, output ready);
endinterface
`default_nettype wire

/* sv/ocvm_cell.sv */
`default_nettype none
module ocvm_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  ocvm_pkg::cell_cmd_t   cmd,
  input  logic                  upd_en,
  input  ocvm_pkg::vm_state_t   nbr,
  output ocvm_pkg::vm_state_t   state
);
  import ocvm_pkg::*;

  vm_state_t fresh;

  always_comb begin
    fresh = nbr;
    if (upd_en && cmd.rel) begin
      fresh.job = (nbr.job != '0) ? nbr.job - JOB_W'(1) : '0;
      fresh.mem = (nbr.mem > USE_W'(cmd.mem_amt)) ? nbr.mem - USE_W'(cmd.mem_amt) : '0;
      fresh.net = (nbr.net > USE_W'(cmd.net_amt)) ? nbr.net - USE_W'(cmd.net_amt) : '0;
    end else if (upd_en && cmd.asg) begin
      fresh.job = (nbr.job == JOB_MAX) ? JOB_MAX : nbr.job + JOB_W'(1);
      fresh.mem = sat_use({1'b0, nbr.mem} + (USE_W + 1)'(cmd.mem_amt));
      fresh.net = sat_use({1'b0, nbr.net} + (USE_W + 1)'(cmd.net_amt));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (cmd.shift) begin
      state <= fresh;
    end
  end

endmodule
`default_nettype wire

/* sv/ocvm_pow.sv */
`default_nettype none
module ocvm_pow (
  input  logic                          clk,
  input  logic [ocvm_pkg::USE_W-1:0]    usage,
  input  logic [ocvm_pkg::LOG_W-1:0]    log2n,
  output logic [ocvm_pkg::COST_W-1:0]   pow_out
);
  import ocvm_pkg::*;

  localparam int PROD_W = USE_W + LOG_W;

  logic [PROD_W-1:0] exp_prod;
  logic [ROOT_W-1:0] m_q [NUM_ROOTS+1];
  logic [FRAC_W-1:0] fr_q [NUM_ROOTS+1];
  logic [2:0] ip_q [NUM_ROOTS+1];
  logic sat_q [NUM_ROOTS+1];
  logic [ROOT_W+8-1:0] shifted;
  logic [COST_W:0] rounded;

  assign exp_prod = PROD_W'(usage) * PROD_W'(log2n);
  assign m_q[0] = ROOT_W'(1) << 30;

  always_ff @(posedge clk) begin
    fr_q[0] <= exp_prod[27:12];
    ip_q[0] <= exp_prod[30:28];
    sat_q[0] <= |exp_prod[PROD_W-1:31];
  end

  for (genvar k = 0; k < NUM_ROOTS; k++) begin : g_stage
    logic [2*ROOT_W-1:0] prod;
    logic [2*ROOT_W-1:0] rnd;
    assign prod = (2*ROOT_W)'(m_q[k]) * (2*ROOT_W)'(ROOTS[k]);
    assign rnd = prod + ((2*ROOT_W)'(1) << 29);
    always_ff @(posedge clk) begin
      m_q[k+1] <= fr_q[k][FRAC_W-1-k] ? rnd[60:30] : m_q[k];
      fr_q[k+1] <= fr_q[k];
      ip_q[k+1] <= ip_q[k];
      sat_q[k+1] <= sat_q[k];
    end
  end

  assign shifted = ((ROOT_W+8)'(m_q[NUM_ROOTS]) << ip_q[NUM_ROOTS]) + (ROOT_W+8)'(14'h2000);
  assign rounded = shifted[ROOT_W+8-1:14];

  always_ff @(posedge clk) begin
    pow_out <= (sat_q[NUM_ROOTS] || rounded[COST_W]) ? COST_MAX : rounded[COST_W-1:0];
  end

endmodule
`default_nettype wire

/* sv/opportunity_cost_vm_selector_unit.sv */
// Release: the VM ring is rotated until the entry reaches the head, where it is updated.
// Assign: ring seek to the round-robin start, one VM per cycle through the 20-stage cost
// pipeline, drain, and a second seek to the winner.
// One request is in work at a time; a new request is taken while a result waits.
// Reset (rst, synchronous) clears all VM counts, the round-robin pointer and the job limit
// at once, and sets vm_count to 64 and log2_vm_count to 6.0.
`default_nettype none
module opportunity_cost_vm_selector_unit (
  input  logic                               clk,
  input  logic                               rst,
  ocvm_req_if.sink                           req,
  ocvm_res_if.source                         res,
  input  logic                               cfg_we,
  input  logic [ocvm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ocvm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ocvm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SEEK  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_FIN   = 5'b10000
  } fsm_t;

  fsm_t state;
  logic [VMC_W-1:0] vm_count;
  logic [LOG_W-1:0] log2n;
  logic [VM_W-1:0] last_choice;
  logic [LIM_W-1:0] limit;
  logic [VM_W-1:0] head_id;
  logic [VM_W-1:0] head_id_next;
  logic op;
  logic [VM_W-1:0] target;
  logic [AMT_W-1:0] mem_amt;
  logic [AMT_W-1:0] net_amt;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0] n_act;
  logic [VM_W-1:0] best_id;
  logic [COST_W:0] best_cost;

  logic [CNT_W-1:0] n_calc;
  logic [CNT_W-1:0] start_inc;
  logic [VM_W-1:0] start;
  logic accept;
  logic rotate;
  logic apply_rel;
  logic apply_asg;
  logic out_free;
  logic [JOB_W:0] job_inc;

  cell_cmd_t cmd;
  vm_state_t cell_state [MAX_VMS];
  vm_state_t head;

  logic [USE_W-1:0] use_q [NUM_LANES];
  logic [COST_W-1:0] pow_q [NUM_LANES];
  scan_tag_t tag_a;
  scan_tag_t tag_d [POW_LAT];
  scan_tag_t tag_c;
  logic [COST_W-1:0] cost_c;
  logic [COST_W+1:0] cost_sum;
  logic [COST_W-1:0] t_job;
  logic [COST_W-1:0] t_mem;
  logic [COST_W-1:0] t_net;

  assign head = cell_state[0];
  assign req.ready = (state == S_IDLE);
  assign accept = req.valid && req.ready;
  assign out_free = !res.valid || res.ready;
  assign head_id_next = (head_id == VM_W'(MAX_VMS - 1)) ? '0 : head_id + VM_W'(1);
  assign job_inc = {1'b0, head.job} + (JOB_W + 1)'(1);

  always_comb begin
    if (vm_count == '0) begin
      n_calc = CNT_W'(1);
    end else if (32'(vm_count) > 32'(MAX_VMS)) begin
      n_calc = CNT_W'(MAX_VMS);
    end else begin
      n_calc = CNT_W'(vm_count);
    end
    start_inc = CNT_W'(last_choice) + CNT_W'(1);
    start = (start_inc >= n_calc) ? '0 : VM_W'(start_inc);
  end

  always_comb begin
    rotate = 1'b0;
    apply_rel = 1'b0;
    apply_asg = 1'b0;
    unique case (state)
      S_IDLE: ;
      S_SEEK: begin
        rotate = (head_id != target) || (op == REQ_RELEASE);
        apply_rel = (head_id == target) && (op == REQ_RELEASE);
      end
      S_SCAN: rotate = 1'b1;
      S_DRAIN: ;
      S_FIN: begin
        rotate = (head_id != best_id) || out_free;
        apply_asg = (head_id == best_id) && out_free;
      end
      default: ;
    endcase
  end

  assign cmd.shift = rotate;
  assign cmd.rel = apply_rel;
  assign cmd.asg = apply_asg;
  assign cmd.mem_amt = mem_amt;
  assign cmd.net_amt = net_amt;

  for (genvar k = 0; k < MAX_VMS; k++) begin : g_cell
    ocvm_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd),
      .upd_en (k == MAX_VMS - 1),
      .nbr    (cell_state[(k + 1) % MAX_VMS]),
      .state  (cell_state[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm_count <= VM_COUNT_RESET;
      log2n <= LOG2_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VM_COUNT: vm_count <= cfg_data[VMC_W-1:0];
        CFG_LOG2_VM_COUNT: log2n <= cfg_data[LOG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      last_choice <= '0;
      limit <= '0;
      head_id <= '0;
      res.valid <= 1'b0;
      step <= '0;
    end else begin
      if (apply_asg) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      if (rotate) begin
        head_id <= head_id_next;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op <= req.req_type;
            mem_amt <= req.mem_amount;
            net_amt <= req.net_amount;
            best_cost <= {1'b1, {COST_W{1'b0}}};
            n_act <= n_calc;
            if (req.req_type == REQ_RELEASE) begin
              target <= VM_W'(req.vm_index);
              if (32'(req.vm_index) < 32'(MAX_VMS)) begin
                state <= S_SEEK;
              end
            end else begin
              target <= start;
              state <= S_SEEK;
            end
          end
        end
        S_SEEK: begin
          if (head_id == target) begin
            step <= '0;
            state <= (op == REQ_RELEASE) ? S_IDLE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (step == STEP_W'(MAX_VMS - 1)) begin
            step <= '0;
            state <= S_DRAIN;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        S_DRAIN: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(DRAIN_LEN - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (apply_asg) begin
            if (32'(job_inc) >= (32'(1) << limit) && limit < LIM_TOP) begin
              limit <= limit + LIM_W'(1);
              res.job_limit_log2 <= limit + LIM_W'(1);
            end else begin
              res.job_limit_log2 <= limit;
            end
            last_choice <= best_id;
            res.target_vm <= OUT_VM_W'(best_id);
            res.least_cost <= best_cost[COST_W-1:0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (tag_c.valid && tag_c.active && ({1'b0, cost_c} < best_cost)) begin
        best_cost <= {1'b0, cost_c};
        best_id <= tag_c.id;
      end
    end
  end

  always_ff @(posedge clk) begin
    use_q[0] <= sat_use((USE_W + 1)'(({job_inc, 16'h0000}) >> limit));
    use_q[1] <= sat_use((USE_W + 1)'(({head.job, 16'h0000}) >> limit));
    use_q[2] <= sat_use({1'b0, head.mem} + (USE_W + 1)'(mem_amt));
    use_q[3] <= head.mem;
    use_q[4] <= sat_use({1'b0, head.net} + (USE_W + 1)'(net_amt));
    use_q[5] <= head.net;
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    ocvm_pow u_pow (
      .clk     (clk),
      .usage   (use_q[l]),
      .log2n   (log2n),
      .pow_out (pow_q[l])
    );
  end

  assign t_job = (pow_q[0] > pow_q[1]) ? pow_q[0] - pow_q[1] : '0;
  assign t_mem = (pow_q[2] > pow_q[3]) ? pow_q[2] - pow_q[3] : '0;
  assign t_net = (pow_q[4] > pow_q[5]) ? pow_q[4] - pow_q[5] : '0;
  assign cost_sum = (COST_W + 2)'(t_job) + (COST_W + 2)'(t_mem) + (COST_W + 2)'(t_net);

  always_ff @(posedge clk) begin
    cost_c <= (cost_sum > (COST_W + 2)'(COST_MAX)) ? COST_MAX : cost_sum[COST_W-1:0];
    tag_a.active <= CNT_W'(head_id) < n_act;
    tag_a.id <= head_id;
    for (int d = 0; d < POW_LAT; d++) begin
      tag_d[d].active <= (d == 0) ? tag_a.active : tag_d[(d == 0) ? 0 : d - 1].active;
      tag_d[d].id <= (d == 0) ? tag_a.id : tag_d[(d == 0) ? 0 : d - 1].id;
    end
    tag_c.active <= tag_d[POW_LAT-1].active;
    tag_c.id <= tag_d[POW_LAT-1].id;
    if (rst) begin
      tag_a.valid <= 1'b0;
      tag_c.valid <= 1'b0;
      for (int d = 0; d < POW_LAT; d++) begin
        tag_d[d].valid <= 1'b0;
      end
    end else begin
      tag_a.valid <= (state == S_SCAN);
      for (int d = 0; d < POW_LAT; d++) begin
        tag_d[d].valid <= (d == 0) ? tag_a.valid : tag_d[(d == 0) ? 0 : d - 1].valid;
      end
      tag_c.valid <= tag_d[POW_LAT-1].valid;
    end
  end

endmodule
`default_nettype wire

/* sv/ocvm_checker.sv */
`default_nettype none
module ocvm_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               res_valid,
  input logic                               res_ready,
  input logic [ocvm_pkg::OUT_VM_W-1:0]      target_vm,
  input logic [ocvm_pkg::LIM_W-1:0]         job_limit_log2,
  input logic [ocvm_pkg::COST_W-1:0]        least_cost,
  input logic                               cfg_we,
  input logic [ocvm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [ocvm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ocvm_pkg::*;

  logic [VMC_W-1:0] vm_count;
  logic [LIM_W-1:0] lim_seen;
  logic [CNT_W-1:0] n_mir;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm_count <= VM_COUNT_RESET;
      lim_seen <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_VM_COUNT) begin
        vm_count <= cfg_data[VMC_W-1:0];
      end
      if (res_valid && res_ready) begin
        lim_seen <= job_limit_log2;
      end
    end
  end

  assign n_mir = (vm_count == '0) ? CNT_W'(1) :
                 (32'(vm_count) > 32'(MAX_VMS)) ? CNT_W'(MAX_VMS) : CNT_W'(vm_count);

  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(target_vm) && $stable(least_cost))
    else $error("stalled result changed");

  a_target_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> 32'(target_vm) < 32'(n_mir))
    else $error("chosen VM outside the active set");

  a_limit_grows: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> job_limit_log2 >= lim_seen)
    else $error("job limit went down");

endmodule

bind opportunity_cost_vm_selector_unit ocvm_checker u_ocvm_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .target_vm      (res.target_vm),
  .job_limit_log2 (res.job_limit_log2),
  .least_cost     (res.least_cost),
  .cfg_we         (cfg_we),
  .cfg_index      (cfg_index),
  .cfg_data       (cfg_data)
);
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
module testbench;
  import ocvm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int SETTLE = 2 * MAX_VMS + PIPE_LAT + 40;

  typedef struct {
    logic [OUT_VM_W-1:0] target;
    logic [LIM_W-1:0] lim;
    logic [COST_W-1:0] cost;
  } pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ocvm_req_if req ();
  ocvm_res_if res ();

  opportunity_cost_vm_selector_unit u_top (
    .clk(clk), .rst(rst), .req(req.sink), .res(res.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [63:0] sqrt_steps [NUM_ROOTS];
  logic [6:0] n_vms = VM_COUNT_RESET;
  logic [14:0] log_base = LOG2_RESET;
  logic [16:0] jobs [MAX_VMS];
  logic [19:0] mem_load [MAX_VMS];
  logic [19:0] net_load [MAX_VMS];
  int last_pick;
  int limit_exp;
  pick_t expected_picks [$];
  int errors = 0;
  int cycles = 0;
  int n_assign = 0;
  int n_release = 0;
  int n_checked = 0;
  int n_configs = 0;
  bit calm = 1'b0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'h1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [19:0] clip_use(input logic [63:0] v);
    return v > 64'hFFFFF ? 20'hFFFFF : v[19:0];
  endfunction

  function automatic logic [63:0] power_of_n(input logic [19:0] usage);
    logic [63:0] e;
    logic [63:0] m;
    logic [63:0] v;
    int ip;
    e = (64'(usage) * 64'(log_base)) >> 12;
    ip = int'(e >> 16);
    m = 64'h1 << 30;
    if (ip >= 8) return 64'hFFFFFF;
    for (int k = 0; k < 16; k++)
      if (e[15 - k]) m = (m * sqrt_steps[k] + (64'h1 << 29)) >> 30;
    v = ((m << ip) + (64'h1 << 13)) >> 14;
    return v > 64'hFFFFFF ? 64'hFFFFFF : v;
  endfunction

  function automatic logic [63:0] step_cost(input logic [19:0] from, input logic [19:0] to);
    logic [63:0] a;
    logic [63:0] b;
    a = power_of_n(to);
    b = power_of_n(from);
    return a > b ? a - b : 0;
  endfunction

  function automatic logic [19:0] job_usage(input logic [16:0] count);
    return clip_use((64'(count) << 16) >> limit_exp);
  endfunction

  function automatic void pick_vm(input logic [15:0] mem, input logic [15:0] net);
    int n;
    int i;
    int best;
    logic [63:0] best_cost;
    logic [63:0] c;
    logic [16:0] grown;
    pick_t p;
    n = (n_vms == 0) ? 1 : int'(n_vms);
    if (n > MAX_VMS) n = MAX_VMS;
    best = 0;
    best_cost = 64'h1000000;
    i = last_pick + 1;
    for (int s = 0; s < n; s++, i++) begin
      if (i >= n) i = 0;
      c = step_cost(job_usage(jobs[i]), job_usage(jobs[i] + 17'd1))
        + step_cost(mem_load[i], clip_use(64'(mem_load[i]) + mem))
        + step_cost(net_load[i], clip_use(64'(net_load[i]) + net));
      if (c > 64'hFFFFFF) c = 64'hFFFFFF;
      if (c < best_cost) begin
        best_cost = c;
        best = i;
      end
    end
    grown = jobs[best] + 17'd1;
    if (64'(grown) >= (64'h1 << limit_exp) && limit_exp < 15) limit_exp++;
    jobs[best] = grown > 17'hFFFF ? 17'hFFFF : grown;
    mem_load[best] = clip_use(64'(mem_load[best]) + mem);
    net_load[best] = clip_use(64'(net_load[best]) + net);
    last_pick = best;
    p.target = best[5:0];
    p.lim = limit_exp[3:0];
    p.cost = best_cost[23:0];
    expected_picks.push_back(p);
  endfunction

  function automatic void drop_job(input logic [5:0] idx, input logic [15:0] mem,
                                   input logic [15:0] net);
    jobs[idx] = jobs[idx] > 0 ? jobs[idx] - 17'd1 : 17'd0;
    mem_load[idx] = mem_load[idx] > mem ? mem_load[idx] - mem : 20'd0;
    net_load[idx] = net_load[idx] > net ? net_load[idx] - net : 20'd0;
  endfunction

  initial begin
    sqrt_steps[0] = int_sqrt(64'h1 << 61);
    for (int k = 1; k < NUM_ROOTS; k++) sqrt_steps[k] = int_sqrt(sqrt_steps[k - 1] << 30);
    for (int i = 0; i < MAX_VMS; i++) begin
      jobs[i] = 0;
      mem_load[i] = 0;
      net_load[i] = 0;
    end
    last_pick = 0;
    limit_exp = 0;
  end

  initial begin
    req.valid = 1'b0;
    req.req_type = REQ_ASSIGN;
    req.vm_index = '0;
    req.mem_amount = '0;
    req.net_amount = '0;
    res.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("FAIL opportunity_cost_vm_selector_unit");
      $finish;
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    pick_t p;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_picks.size() == 0) begin
          errors++;
          $display("%0t: unexpected result vm=%0d lim=%0d cost=%0h", $time,
                   res.target_vm, res.job_limit_log2, res.least_cost);
        end else begin
          p = expected_picks.pop_front();
          n_checked++;
          if (res.target_vm !== p.target) begin
            errors++;
            $display("%0t: target_vm expected %0d got %0d", $time, p.target, res.target_vm);
          end
          if (res.job_limit_log2 !== p.lim) begin
            errors++;
            $display("%0t: job_limit_log2 expected %0d got %0d", $time, p.lim,
                     res.job_limit_log2);
          end
          if (res.least_cost !== p.cost) begin
            errors++;
            $display("%0t: least_cost expected %0h got %0h", $time, p.cost, res.least_cost);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        res.ready <= 1'b0;
      end else if (res.valid && res.ready) begin
        if (!calm && $urandom_range(0, 1)) begin
          stall_left <= $urandom_range(0, 11);
          res.ready <= 1'b0;
        end else begin
          res.ready <= 1'b1;
        end
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic kind, input logic [5:0] idx, input logic [15:0] mem,
                           input logic [15:0] net);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= kind;
    req.vm_index <= idx;
    req.mem_amount <= mem;
    req.net_amount <= net;
    do @(posedge clk); while (!req.ready);
    if (kind == REQ_ASSIGN) begin
      n_assign++;
      pick_vm(mem, net);
    end else begin
      n_release++;
      drop_job(idx, mem, net);
    end
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [14:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx == CFG_VM_COUNT) n_vms = value[6:0];
    else log_base = value;
    n_configs++;
  endtask

  task automatic set_config(input logic [6:0] count, input logic [14:0] lg);
    wait_drained();
    write_reg(CFG_VM_COUNT, 15'(count));
    write_reg(CFG_LOG2_VM_COUNT, lg);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed_extremes();
    send_item(REQ_ASSIGN, 6'd0, 16'h0000, 16'h0000);
    send_item(REQ_ASSIGN, 6'd63, 16'hFFFF, 16'hFFFF);
    send_item(REQ_ASSIGN, 6'd0, 16'hFFFF, 16'h0000);
    send_item(REQ_ASSIGN, 6'd0, 16'h0000, 16'hFFFF);
    send_item(REQ_RELEASE, 6'd1, 16'hFFFF, 16'hFFFF);
    send_item(REQ_RELEASE, 6'd63, 16'hFFFF, 16'hFFFF);
    send_item(REQ_RELEASE, 6'd0, 16'h0001, 16'h0001);
    send_item(REQ_ASSIGN, 6'd63, 16'h8000, 16'h0001);
  endtask

  task automatic test_single_vm_saturation();
    set_config(7'd1, 15'd0);
    for (int k = 0; k < 18; k++) send_item(REQ_ASSIGN, 6'd0, 16'hFFFF, 16'hFFFF);
    set_config(7'd2, 15'd4096);
    for (int k = 0; k < 6; k++) send_item(REQ_ASSIGN, 6'd0, 16'hFFFF, 16'h1234);
  endtask

  task automatic test_odd_counts();
    set_config(7'd0, 15'd32767);
    send_item(REQ_ASSIGN, 6'd5, 16'h0100, 16'h0200);
    set_config(7'd127, 15'd24576);
    for (int k = 0; k < 4; k++) send_item(REQ_ASSIGN, 6'd0, 16'h0010, 16'h0020);
    set_config(7'd64, 15'd24576);
    for (int k = 0; k < 3; k++) send_item(REQ_ASSIGN, 6'd0, 16'h0000, 16'h0000);
    set_config(7'd3, 15'd6492);
    send_item(REQ_ASSIGN, 6'd0, 16'h4000, 16'h4000);
  endtask

  task automatic test_random_phase(input logic [6:0] count, input logic [14:0] lg,
                                   input int items);
    int top;
    logic [15:0] mem;
    logic [15:0] net;
    set_config(count, lg);
    calm = ($urandom_range(0, 3) == 0);
    top = (count == 0) ? 0 : ((count > MAX_VMS) ? MAX_VMS - 1 : count - 1);
    for (int k = 0; k < items; k++) begin
      case ($urandom_range(0, 3))
        0: mem = 16'($urandom);
        1: mem = 16'($urandom_range(0, 255));
        2: mem = 16'hFFFF - 16'($urandom_range(0, 15));
        default: mem = 16'($urandom_range(0, 4095));
      endcase
      net = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8191));
      if ($urandom_range(0, 9) < 6) begin
        send_item(REQ_ASSIGN, 6'($urandom), mem, net);
      end else if ($urandom_range(0, 4) == 0) begin
        send_item(REQ_RELEASE, 6'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        send_item(REQ_RELEASE, 6'($urandom_range(0, top)), mem, net);
      end
      if (k == items / 2 && $urandom_range(0, 1)) begin
        req.valid <= 1'b0;
        @(posedge clk);
        while (expected_picks.size() != 0) @(posedge clk);
      end
    end
    calm = 1'b0;
  endtask

  task automatic test_random();
    test_random_phase(7'd64, 15'd24576, 200);
    test_random_phase(7'd1, 15'd0, 120);
    test_random_phase(7'd2, 15'd4096, 150);
    test_random_phase(7'd5, 15'd9510, 170);
    test_random_phase(7'd127, 15'd32767, 150);
    test_random_phase(7'd16, 15'd16384, 180);
    test_random_phase(7'd0, 15'd12000, 60);
    test_random_phase(7'($urandom_range(1, 64)), 15'($urandom), 170);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_single_vm_saturation();
    test_odd_counts();
    test_random();
    wait_drained();
    $display("Covered %0d assigns and %0d releases over %0d register writes;", n_assign,
             n_release, n_configs);
    $display("%0d results checked, %0d mismatches.", n_checked, errors);
    if (errors == 0 && expected_picks.size() == 0) begin
      $display("PASS opportunity_cost_vm_selector_unit");
    end else begin
      $display("FAIL opportunity_cost_vm_selector_unit");
    end
    $finish;
  end
endmodule
`default_nettype wire
